/* design/srqt_pkg.sv */
// ----------------------------------------------------------------------------
// srqt_pkg: shared types and constants for the scope refcount / quota table
// Holds the slot geometry, action codes, status codes and the packed slot
// record that is stored in the table memory.
// ----------------------------------------------------------------------------
package srqt_pkg;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned ID_W = 32;
  localparam int unsigned MEM_W = 7;
  localparam int unsigned QTY_W = 24;
  localparam int unsigned TOT_W = 30;
  localparam int unsigned CAP_W = 7;
  localparam int unsigned ACC_W = 38;

  localparam logic [MEM_W-1:0] MEMBERS_MAX = 7'd127;
  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  localparam logic [3:0] ACT_ACQUIRE   = 4'd0;
  localparam logic [3:0] ACT_RELEASE   = 4'd1;
  localparam logic [3:0] ACT_PRESERVE  = 4'd2;
  localparam logic [3:0] ACT_RECLAIM   = 4'd3;
  localparam logic [3:0] ACT_REAP      = 4'd4;
  localparam logic [3:0] ACT_RESERVE   = 4'd5;
  localparam logic [3:0] ACT_UNRESERVE = 4'd6;
  localparam logic [3:0] ACT_GUARANTEE = 4'd7;
  localparam logic [3:0] ACT_STATUS    = 4'd8;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REFUSE = 2'd1;
  localparam logic [1:0] ST_FAULT  = 2'd2;

  localparam logic [1:0] CFG_FIRST = 2'd0;
  localparam logic [1:0] CFG_MAXACT = 2'd1;
  localparam logic [1:0] CFG_LCAP = 2'd2;

  typedef struct packed {
    logic             used;
    logic [ID_W-1:0]  scope;
    logic [MEM_W-1:0] members;
    logic             retiring;
    logic             preserve;
    logic [QTY_W-1:0] blocks;
    logic [QTY_W-1:0] inodes;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

/* design/srqt_ram.sv */
// ----------------------------------------------------------------------------
// srqt_ram: generic single-port-write, single-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module srqt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/scope_refcount_quota_table.sv */
// ----------------------------------------------------------------------------
// scope_refcount_quota_table: scope refcount and quota table
// flow: each transaction scans all 64 slots through the single table read port,
//   then drains the read pipeline and decides (plus a total step for a guarantee
//   query with a nonzero amount); in_stall holds new input until the result is taken
// reset: synchronous; a clearing pass zeroes every slot before the first
//   transaction is taken
// ----------------------------------------------------------------------------
module scope_refcount_quota_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  action,
  input  logic [31:0] scope_key,
  input  logic        counter_kind,
  input  logic [23:0] amount,
  input  logic        outside_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        last_member,
  output logic        slot_retired,
  output logic        was_eligible,
  output logic        keep_files,
  output logic        reap_found,
  output logic [31:0] reap_scope,
  output logic [29:0] required_total,
  output logic        is_active,
  output logic        is_retiring,
  output logic        is_retained,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_WRITE, S_OUT
  } state_t;

  localparam logic [srqt_pkg::CNT_W-1:0] LAST_CNT = srqt_pkg::CNT_W'(srqt_pkg::SLOTS);

  state_t state;
  logic [31:0] first_dyn;
  logic [srqt_pkg::CAP_W-1:0] max_active, lifecycle_cap;

  logic [3:0] act_q;
  logic [31:0] id_q;
  logic kind_q, ok_q;
  logic [23:0] amt_q;

  logic [srqt_pkg::CNT_W-1:0] issue_cnt;   // read addresses issued
  logic [srqt_pkg::IDX_W-1:0] rd_idx;      // index of data now on rdata
  logic rd_live;
  logic [srqt_pkg::IDX_W-1:0] reap_cursor;

  logic found, free_found, reap_hit;
  logic [srqt_pkg::IDX_W-1:0] hit_idx, free_idx, reap_idx;
  logic [srqt_pkg::IDX_W-1:0] reap_ofs;
  srqt_pkg::slot_t hit_slot;
  logic [31:0] reap_id;
  logic [srqt_pkg::CNT_W-1:0] n_active, n_retiring;
  logic [srqt_pkg::ACC_W-1:0] acc;

  logic we;
  logic [srqt_pkg::IDX_W-1:0] waddr, raddr;
  srqt_pkg::slot_t wdata, rslot;
  logic [srqt_pkg::SLOT_W-1:0] rbits;

  srqt_ram #(.WIDTH(srqt_pkg::SLOT_W), .DEPTH(srqt_pkg::SLOTS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rbits)
  );
  assign rslot = srqt_pkg::slot_t'(rbits);
  assign raddr = issue_cnt[srqt_pkg::IDX_W-1:0];

  // result fields
  logic [1:0] r_status;
  logic r_last, r_retired, r_elig, r_keep, r_rfound, r_act, r_ret, r_retd;
  logic [31:0] r_rscope;
  logic [29:0] r_total;

  logic low;
  assign low = id_q < first_dyn;

  assign in_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign out_valid = (state == S_OUT);

  // shared per-slot evaluation of the word on the read port
  logic r_isact, r_iser, r_match;
  logic [23:0] r_used;
  logic [24:0] r_gap;
  assign r_isact = rslot.used && !rslot.retiring && (rslot.members != '0);
  assign r_iser = rslot.used && rslot.retiring && (rslot.members == '0);
  assign r_match = rslot.used && (rslot.scope == id_q);
  assign r_used = kind_q ? rslot.inodes : rslot.blocks;
  assign r_gap = {1'b0, amt_q} - {1'b0, r_used};
  // distance from the reap cursor, wrapping around the table
  logic [srqt_pkg::IDX_W-1:0] ring_ofs;
  assign ring_ofs = rd_idx - reap_cursor;

  // guarantee tail product: (max_active - active) * amount
  logic [srqt_pkg::CAP_W-1:0] spare;
  logic [30:0] tail;
  assign spare = max_active - srqt_pkg::CAP_W'(n_active);
  assign tail = {24'b0, spare} * {7'b0, amt_q};

  srqt_pkg::slot_t mod;
  logic [1:0] d_status;
  logic d_we, d_last, d_ret, d_elig, d_keep;
  logic [srqt_pkg::IDX_W-1:0] d_addr;
  logic d_reap;
  assign d_reap = (act_q == srqt_pkg::ACT_REAP) && reap_hit;

  always_comb begin
    mod = hit_slot;
    d_status = srqt_pkg::ST_OK;
    d_we = 1'b0;
    d_last = 1'b0;
    d_ret = 1'b0;
    d_elig = 1'b0;
    d_keep = 1'b0;
    d_addr = hit_idx;
    case (act_q)
      srqt_pkg::ACT_ACQUIRE: begin
        if (low) begin
          d_status = srqt_pkg::ST_REFUSE;
        end else if (found) begin
          if (hit_slot.retiring || hit_slot.members == '0 ||
              hit_slot.members >= srqt_pkg::MEMBERS_MAX) begin
            d_status = srqt_pkg::ST_REFUSE;
          end else begin
            mod.members = hit_slot.members + 1'b1;
            d_we = 1'b1;
          end
        end else if (free_found && ({1'b0, n_active} < {1'b0, max_active}) &&
                     ({1'b0, n_active} + {1'b0, n_retiring} < {1'b0, lifecycle_cap}) &&
                     ok_q) begin
          mod = '0;
          mod.used = 1'b1;
          mod.scope = id_q;
          mod.members = 7'd1;
          d_addr = free_idx;
          d_we = 1'b1;
        end else begin
          d_status = srqt_pkg::ST_REFUSE;
        end
      end
      srqt_pkg::ACT_RELEASE: begin
        if (low || !found) begin
          d_status = srqt_pkg::ST_REFUSE;
        end else if (hit_slot.members == '0) begin
          d_status = srqt_pkg::ST_FAULT;
        end else begin
          mod.members = hit_slot.members - 1'b1;
          d_we = 1'b1;
          if (hit_slot.members == 7'd1) begin
            mod.retiring = 1'b1;
            d_last = 1'b1;
          end
        end
      end
      srqt_pkg::ACT_PRESERVE: begin
        if (found && !hit_slot.retiring && hit_slot.members != '0) begin
          mod.preserve = 1'b1;
          d_we = 1'b1;
        end else begin
          d_status = srqt_pkg::ST_REFUSE;
        end
      end
      srqt_pkg::ACT_RECLAIM: begin
        if (low || !found) begin
          d_status = srqt_pkg::ST_REFUSE;
        end else begin
          d_elig = hit_slot.retiring && hit_slot.members == '0;
          d_keep = hit_slot.preserve;
          if (d_elig && ok_q) begin
            if (hit_slot.preserve) begin
              mod.retiring = 1'b0;
              d_we = 1'b1;
            end else if (hit_slot.blocks == '0 && hit_slot.inodes == '0) begin
              mod = '0;
              d_we = 1'b1;
              d_ret = 1'b1;
            end
          end
        end
      end
      srqt_pkg::ACT_REAP: begin
        d_status = reap_hit ? srqt_pkg::ST_OK : srqt_pkg::ST_REFUSE;
      end
      srqt_pkg::ACT_RESERVE: begin
        if (low || amt_q == '0 || !found) begin
          d_status = srqt_pkg::ST_REFUSE;
        end else if (!hit_slot.retiring && hit_slot.members != '0 &&
                     (kind_q ? hit_slot.inodes : hit_slot.blocks) < amt_q) begin
          d_we = 1'b1;
          if (kind_q) mod.inodes = hit_slot.inodes + 1'b1;
          else mod.blocks = hit_slot.blocks + 1'b1;
        end else begin
          d_status = srqt_pkg::ST_REFUSE;
        end
      end
      srqt_pkg::ACT_UNRESERVE: begin
        if (low || !found) begin
          d_status = srqt_pkg::ST_REFUSE;
        end else if ((kind_q ? hit_slot.inodes : hit_slot.blocks) == '0) begin
          d_status = srqt_pkg::ST_FAULT;
        end else begin
          d_we = 1'b1;
          if (kind_q) mod.inodes = hit_slot.inodes - 1'b1;
          else mod.blocks = hit_slot.blocks - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      first_dyn <= 32'd2;
      max_active <= 7'd8;
      lifecycle_cap <= 7'd16;
      issue_cnt <= '0;
      reap_cursor <= '0;
      we <= 1'b0;
      rd_live <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srqt_pkg::CFG_FIRST: first_dyn <= cfg_data;
          srqt_pkg::CFG_MAXACT: max_active <= cfg_data[srqt_pkg::CAP_W-1:0];
          srqt_pkg::CFG_LCAP: lifecycle_cap <= cfg_data[srqt_pkg::CAP_W-1:0];
          default: ;
        endcase
      end
      // read pipeline bookkeeping
      rd_live <= (state == S_SCAN);
      rd_idx <= raddr;
      case (state)
        S_CLEAR: begin
          we <= 1'b1;
          waddr <= issue_cnt[srqt_pkg::IDX_W-1:0];
          wdata <= '0;
          issue_cnt <= issue_cnt + 1'b1;
          if (issue_cnt == LAST_CNT - 1'b1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          we <= 1'b0;
          issue_cnt <= '0;
          if (in_valid) begin
            act_q <= action;
            id_q <= scope_key;
            kind_q <= counter_kind;
            amt_q <= amount;
            ok_q <= outside_ok;
            found <= 1'b0;
            free_found <= 1'b0;
            reap_hit <= 1'b0;
            reap_ofs <= '0;
            n_active <= '0;
            n_retiring <= '0;
            acc <= '0;
            r_act <= 1'b0;
            r_ret <= 1'b0;
            r_retd <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          we <= 1'b0;
          issue_cnt <= issue_cnt + 1'b1;
          if (issue_cnt == LAST_CNT - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last table word is folded in at this edge
          we <= 1'b0;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          r_status <= d_status;
          r_last <= d_last;
          r_retired <= d_ret;
          r_elig <= d_elig;
          r_keep <= d_keep;
          r_rfound <= d_reap;
          r_rscope <= d_reap ? reap_id : '0;
          r_total <= '0;
          we <= d_we;
          waddr <= d_addr;
          wdata <= mod;
          if (d_reap) begin
            reap_cursor <= reap_idx + 1'b1;
          end
          if (act_q == srqt_pkg::ACT_GUARANTEE && amt_q != '0) begin
            acc <= acc + ((max_active > srqt_pkg::CAP_W'(n_active)) ?
                   srqt_pkg::ACC_W'(tail) : '0);
            state <= S_WRITE;
          end else begin
            state <= S_OUT;
          end
        end
        S_WRITE: begin
          we <= 1'b0;
          r_total <= (acc > srqt_pkg::ACC_W'(srqt_pkg::TOTAL_MAX)) ?
                     srqt_pkg::TOTAL_MAX : acc[srqt_pkg::TOT_W-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          we <= 1'b0;
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          we <= 1'b0;
          state <= S_IDLE;
        end
      endcase
      // accumulate one table entry per cycle from the read port
      if (rd_live) begin
        if (r_match && !found) begin
          found <= 1'b1;
          hit_idx <= rd_idx;
          hit_slot <= rslot;
        end
        if (!rslot.used && !free_found) begin
          free_found <= 1'b1;
          free_idx <= rd_idx;
        end
        if (r_isact) n_active <= n_active + 1'b1;
        if (r_iser) n_retiring <= n_retiring + 1'b1;
        if (r_iser && (!reap_hit || ring_ofs < reap_ofs)) begin
          reap_hit <= 1'b1;
          reap_ofs <= ring_ofs;
          reap_idx <= rd_idx;
          reap_id <= rslot.scope;
        end
        if (r_isact && !r_match && !r_gap[24]) begin
          acc <= acc + srqt_pkg::ACC_W'(r_gap[23:0]);
        end
        if (r_match && act_q == srqt_pkg::ACT_STATUS) begin
          r_retd <= 1'b1;
          if (rslot.members != '0) r_act <= 1'b1;
          if (rslot.retiring && rslot.members == '0) r_ret <= 1'b1;
        end
      end
    end
  end

  assign status = r_status;
  assign last_member = r_last;
  assign slot_retired = r_retired;
  assign was_eligible = r_elig;
  assign keep_files = r_keep;
  assign reap_found = r_rfound;
  assign reap_scope = r_rscope;
  assign required_total = r_total;
  assign is_active = r_act;
  assign is_retiring = r_ret;
  assign is_retained = r_retd;

endmodule

/* design/srqt_checker.sv */
// ----------------------------------------------------------------------------
// srqt_checker: port-level checks for the scope refcount / quota table
// Watches the handshakes and result flags seen at the top level.
// ----------------------------------------------------------------------------
module srqt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        reap_found,
  input logic        slot_retired,
  input logic        was_eligible
);

  // no new transaction while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid |-> in_stall) else $error("input taken while result pending");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("result dropped under stall");

  // reap found implies ok status
  a_reap: assert property (@(posedge clk) disable iff (rst)
    out_valid && reap_found |-> status == srqt_pkg::ST_OK)
    else $error("reap found with bad status");

  // a retired slot was eligible
  a_retire: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_retired |-> was_eligible)
    else $error("retire without eligibility");

endmodule

bind scope_refcount_quota_table srqt_checker u_srqt_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .reap_found(reap_found), .slot_retired(slot_retired), .was_eligible(was_eligible)
);

/* tb/tb_scope_refcount_quota_table.sv */
// ----------------------------------------------------------------------------
// tb_scope_refcount_quota_table: self-checking bench for the scope table
// Drives actions through the valid/stall input channel, predicts every result
// with a behavioral copy of the slot table, and compares each result field
// against the oldest prediction. Runs several register settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_scope_refcount_quota_table;

  localparam logic [3:0] ACT_NONE = 4'd9;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] scope_key;
    logic        counter_kind;
    logic [23:0] amount;
    logic        outside_ok;
  } op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        last_member;
    logic        slot_retired;
    logic        was_eligible;
    logic        keep_files;
    logic        reap_found;
    logic [31:0] reap_scope;
    logic [29:0] required_total;
    logic        is_active;
    logic        is_retiring;
    logic        is_retained;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] action = '0;
  logic [31:0] scope_key = '0;
  logic counter_kind = 1'b0;
  logic [23:0] amount = '0;
  logic outside_ok = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic last_member, slot_retired, was_eligible, keep_files, reap_found;
  logic [31:0] reap_scope;
  logic [29:0] required_total;
  logic is_active, is_retiring, is_retained;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  scope_refcount_quota_table dut (.*);

  always #5 clk = ~clk;

  // predictor state
  srqt_pkg::slot_t tbl [srqt_pkg::SLOTS];
  logic [31:0] p_first;
  logic [6:0] p_maxact, p_lcap;
  logic [srqt_pkg::IDX_W-1:0] p_cursor;

  op_t pending_ops[$];
  res_t expected_results[$];
  int send_idle_pct = 0, stall_pct = 0;
  bit failed = 0;
  int quiet_cycles = 0;

  function automatic bit slot_active(int i);
    return tbl[i].used && !tbl[i].retiring && tbl[i].members != 0;
  endfunction

  function automatic bit slot_empty_retiring(int i);
    return tbl[i].used && tbl[i].retiring && tbl[i].members == 0;
  endfunction

  function automatic int lookup(logic [31:0] id);
    for (int i = 0; i < srqt_pkg::SLOTS; i++)
      if (tbl[i].used && tbl[i].scope == id) return i;
    return -1;
  endfunction

  function automatic res_t predict_table_op(op_t op);
    res_t r;
    int s, open_slot, k;
    int unsigned nact, nret;
    logic [63:0] total;
    logic [23:0] used_cnt;
    bit low;
    r = '0;
    low = op.scope_key < p_first;
    case (op.action)
      srqt_pkg::ACT_ACQUIRE: begin
        if (low) r.status = srqt_pkg::ST_REFUSE;
        else begin
          s = lookup(op.scope_key);
          if (s >= 0) begin
            if (tbl[s].retiring || tbl[s].members == 0 ||
                tbl[s].members >= srqt_pkg::MEMBERS_MAX)
              r.status = srqt_pkg::ST_REFUSE;
            else tbl[s].members++;
          end else begin
            nact = 0; nret = 0; open_slot = -1;
            for (int i = 0; i < srqt_pkg::SLOTS; i++) begin
              if (tbl[i].used) begin
                if (slot_active(i)) nact++;
                else if (slot_empty_retiring(i)) nret++;
              end else if (open_slot < 0) open_slot = i;
            end
            if (open_slot >= 0 && nact < p_maxact && nact + nret < p_lcap && op.outside_ok)
            begin
              tbl[open_slot] = '0;
              tbl[open_slot].used = 1'b1;
              tbl[open_slot].scope = op.scope_key;
              tbl[open_slot].members = 7'd1;
            end else r.status = srqt_pkg::ST_REFUSE;
          end
        end
      end
      srqt_pkg::ACT_RELEASE: begin
        s = low ? -1 : lookup(op.scope_key);
        if (s < 0) r.status = srqt_pkg::ST_REFUSE;
        else if (tbl[s].members == 0) r.status = srqt_pkg::ST_FAULT;
        else begin
          tbl[s].members--;
          if (tbl[s].members == 0) begin
            tbl[s].retiring = 1'b1;
            r.last_member = 1'b1;
          end
        end
      end
      srqt_pkg::ACT_PRESERVE: begin
        s = lookup(op.scope_key);
        if (s >= 0 && slot_active(s)) tbl[s].preserve = 1'b1;
        else r.status = srqt_pkg::ST_REFUSE;
      end
      srqt_pkg::ACT_RECLAIM: begin
        s = low ? -1 : lookup(op.scope_key);
        if (s < 0) r.status = srqt_pkg::ST_REFUSE;
        else begin
          r.was_eligible = slot_empty_retiring(s);
          r.keep_files = tbl[s].preserve;
          if (r.was_eligible && op.outside_ok) begin
            if (tbl[s].preserve) tbl[s].retiring = 1'b0;
            else if (tbl[s].blocks == 0 && tbl[s].inodes == 0) begin
              tbl[s] = '0;
              r.slot_retired = 1'b1;
            end
          end
        end
      end
      srqt_pkg::ACT_REAP: begin
        r.status = srqt_pkg::ST_REFUSE;
        for (int n = 0; n < srqt_pkg::SLOTS; n++) begin
          k = (p_cursor + n) % srqt_pkg::SLOTS;
          if (slot_empty_retiring(k)) begin
            r.status = srqt_pkg::ST_OK;
            r.reap_found = 1'b1;
            r.reap_scope = tbl[k].scope;
            p_cursor = srqt_pkg::IDX_W'((k + 1) % srqt_pkg::SLOTS);
            break;
          end
        end
      end
      srqt_pkg::ACT_RESERVE: begin
        s = (low || op.amount == 0) ? -1 : lookup(op.scope_key);
        if (s < 0) r.status = srqt_pkg::ST_REFUSE;
        else if (!op.counter_kind) begin
          if (slot_active(s) && tbl[s].blocks < op.amount) tbl[s].blocks++;
          else r.status = srqt_pkg::ST_REFUSE;
        end else begin
          if (slot_active(s) && tbl[s].inodes < op.amount) tbl[s].inodes++;
          else r.status = srqt_pkg::ST_REFUSE;
        end
      end
      srqt_pkg::ACT_UNRESERVE: begin
        s = low ? -1 : lookup(op.scope_key);
        if (s < 0) r.status = srqt_pkg::ST_REFUSE;
        else if (!op.counter_kind) begin
          if (tbl[s].blocks == 0) r.status = srqt_pkg::ST_FAULT;
          else tbl[s].blocks--;
        end else begin
          if (tbl[s].inodes == 0) r.status = srqt_pkg::ST_FAULT;
          else tbl[s].inodes--;
        end
      end
      srqt_pkg::ACT_GUARANTEE: begin
        if (op.amount != 0) begin
          total = 0; nact = 0;
          for (int i = 0; i < srqt_pkg::SLOTS; i++) begin
            if (!slot_active(i)) continue;
            nact++;
            if (tbl[i].scope == op.scope_key) continue;
            used_cnt = op.counter_kind ? tbl[i].inodes : tbl[i].blocks;
            if (used_cnt < op.amount) total += op.amount - used_cnt;
          end
          if (nact < p_maxact) total += 64'(p_maxact - nact) * op.amount;
          r.required_total = total > srqt_pkg::TOTAL_MAX ? srqt_pkg::TOTAL_MAX
                                                         : total[29:0];
        end
      end
      srqt_pkg::ACT_STATUS: begin
        for (int i = 0; i < srqt_pkg::SLOTS; i++) begin
          if (!tbl[i].used || tbl[i].scope != op.scope_key) continue;
          r.is_retained = 1'b1;
          if (tbl[i].members != 0) r.is_active = 1'b1;
          if (tbl[i].retiring && tbl[i].members == 0) r.is_retiring = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op_t op;
        op = pending_ops.pop_front();
        expected_results.push_back(predict_table_op(op));
        in_valid <= 1'b1;
        action <= op.action;
        scope_key <= op.scope_key;
        counter_kind <= op.counter_kind;
        amount <= op.amount;
        outside_ok <= op.outside_ok;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      res_t got, want;
      got = '{status, last_member, slot_retired, was_eligible, keep_files, reap_found,
              reap_scope, required_total, is_active, is_retiring, is_retained};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result exp none got %h", $time, got);
        failed = 1;
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        if (got.last_member != want.last_member)
          $display("%0t: last_member exp %0d got %0d", $time, want.last_member,
                   got.last_member);
        if (got.slot_retired != want.slot_retired)
          $display("%0t: slot_retired exp %0d got %0d", $time, want.slot_retired,
                   got.slot_retired);
        if (got.was_eligible != want.was_eligible)
          $display("%0t: was_eligible exp %0d got %0d", $time, want.was_eligible,
                   got.was_eligible);
        if (got.keep_files != want.keep_files)
          $display("%0t: keep_files exp %0d got %0d", $time, want.keep_files,
                   got.keep_files);
        if (got.reap_found != want.reap_found)
          $display("%0t: reap_found exp %0d got %0d", $time, want.reap_found,
                   got.reap_found);
        if (got.reap_scope != want.reap_scope)
          $display("%0t: reap_scope exp %h got %h", $time, want.reap_scope, got.reap_scope);
        if (got.required_total != want.required_total)
          $display("%0t: required_total exp %0d got %0d", $time, want.required_total,
                   got.required_total);
        if (got.is_active != want.is_active)
          $display("%0t: is_active exp %0d got %0d", $time, want.is_active, got.is_active);
        if (got.is_retiring != want.is_retiring)
          $display("%0t: is_retiring exp %0d got %0d", $time, want.is_retiring,
                   got.is_retiring);
        if (got.is_retained != want.is_retained)
          $display("%0t: is_retained exp %0d got %0d", $time, want.is_retained,
                   got.is_retained);
        if (got != want) failed = 1;
      end
    end
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      srqt_pkg::CFG_FIRST: p_first = val;
      srqt_pkg::CFG_MAXACT: p_maxact = val[6:0];
      default: p_lcap = val[6:0];
    endcase
  endtask

  task automatic drain_all();
    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic void queue_op(logic [3:0] a, logic [31:0] id, logic ck,
                                   logic [23:0] amt, logic ok);
    pending_ops.push_back('{a, id, ck, amt, ok});
  endfunction

  // mostly small id pool so actions hit existing slots
  task automatic queue_random_ops(int n, logic [31:0] base);
    logic [3:0] a;
    logic [31:0] id;
    logic [23:0] amt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4: a = srqt_pkg::ACT_ACQUIRE;
        5, 6, 7: a = srqt_pkg::ACT_RELEASE;
        8: a = srqt_pkg::ACT_PRESERVE;
        9, 10: a = srqt_pkg::ACT_RECLAIM;
        11: a = srqt_pkg::ACT_REAP;
        12, 13: a = srqt_pkg::ACT_RESERVE;
        14: a = srqt_pkg::ACT_UNRESERVE;
        15: a = srqt_pkg::ACT_GUARANTEE;
        16, 17: a = srqt_pkg::ACT_STATUS;
        18: a = 4'($urandom_range(15));
        default: a = srqt_pkg::ACT_ACQUIRE;
      endcase
      id = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(11);
      if ($urandom_range(9) == 0) id = $urandom_range(3);
      case ($urandom_range(3))
        0: amt = 24'($urandom_range(4));
        1: amt = 24'($urandom);
        default: amt = 24'($urandom_range(1, 40));
      endcase
      queue_op(a, id, 1'($urandom), amt, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    p_first = 32'd2;
    p_maxact = 7'd8;
    p_lcap = 7'd16;
    p_cursor = '0;
    for (int i = 0; i < srqt_pkg::SLOTS; i++) tbl[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: edges, every action, special cases
    queue_op(srqt_pkg::ACT_ACQUIRE, 32'd1, 1'b0, 24'd0, 1'b1);
    queue_op(srqt_pkg::ACT_ACQUIRE, 32'd5, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_ACQUIRE, 32'd5, 1'b0, 24'd0, 1'b1);
    queue_op(srqt_pkg::ACT_ACQUIRE, 32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF, 1'b1);
    queue_op(srqt_pkg::ACT_RESERVE, 32'd5, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_RESERVE, 32'd5, 1'b0, 24'd2, 1'b0);
    queue_op(srqt_pkg::ACT_RESERVE, 32'd5, 1'b1, 24'hFF_FFFF, 1'b0);
    queue_op(srqt_pkg::ACT_UNRESERVE, 32'hFFFF_FFFF, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_GUARANTEE, 32'd5, 1'b0, 24'hFF_FFFF, 1'b0);
    queue_op(srqt_pkg::ACT_GUARANTEE, 32'd0, 1'b1, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_PRESERVE, 32'hFFFF_FFFF, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_RELEASE, 32'hFFFF_FFFF, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_RELEASE, 32'hFFFF_FFFF, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_ACQUIRE, 32'hFFFF_FFFF, 1'b0, 24'd0, 1'b1);
    queue_op(srqt_pkg::ACT_STATUS, 32'hFFFF_FFFF, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_REAP, 32'd0, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_REAP, 32'd0, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_RECLAIM, 32'hFFFF_FFFF, 1'b0, 24'd0, 1'b1);
    queue_op(srqt_pkg::ACT_RELEASE, 32'd5, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_RECLAIM, 32'd5, 1'b0, 24'd0, 1'b1);
    queue_op(srqt_pkg::ACT_UNRESERVE, 32'd5, 1'b0, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_UNRESERVE, 32'd5, 1'b1, 24'd0, 1'b0);
    queue_op(srqt_pkg::ACT_RECLAIM, 32'd5, 1'b0, 24'd0, 1'b1);
    queue_op(ACT_NONE, 32'd5, 1'b1, 24'hFF_FFFF, 1'b1);
    queue_op(4'd15, 32'd0, 1'b0, 24'd0, 1'b0);
    drain_all();

    // member saturation on one scope
    for (int i = 0; i < 128; i++)
      queue_op(srqt_pkg::ACT_ACQUIRE, 32'd100, 1'b0, 24'd0, 1'b1);
    queue_op(srqt_pkg::ACT_STATUS, 32'd100, 1'b0, 24'd0, 1'b0);
    drain_all();

    send_idle_pct = 69;
    queue_random_ops(200, 32'd2);
    drain_all();

    // extremes of the registers
    write_reg(srqt_pkg::CFG_FIRST, 32'hFFFF_FFF0);
    write_reg(srqt_pkg::CFG_MAXACT, 32'd64);
    write_reg(srqt_pkg::CFG_LCAP, 32'd64);
    send_idle_pct = 0;
    stall_pct = 69;
    queue_random_ops(150, 32'hFFFF_FFF0);
    drain_all();

    write_reg(srqt_pkg::CFG_FIRST, 32'd0);
    write_reg(srqt_pkg::CFG_MAXACT, 32'd0);
    write_reg(srqt_pkg::CFG_LCAP, 32'd0);
    send_idle_pct = 38;
    stall_pct = 38;
    queue_random_ops(80, 32'd0);
    drain_all();

    write_reg(srqt_pkg::CFG_FIRST, 32'd10);
    write_reg(srqt_pkg::CFG_MAXACT, 32'd3);
    write_reg(srqt_pkg::CFG_LCAP, 32'd5);
    send_idle_pct = 0;
    stall_pct = 0;
    queue_random_ops(120, 32'd8);
    drain_all();

    write_reg(srqt_pkg::CFG_MAXACT, 32'd127);
    write_reg(srqt_pkg::CFG_LCAP, 32'd127);
    send_idle_pct = 38;
    stall_pct = 38;
    queue_random_ops(150, 32'd20);
    drain_all();

    send_idle_pct = 0;
    stall_pct = 0;
    if (failed) $display("simulation failed");
    else $display("simulation ok");
    $finish;
  end
endmodule
